// ===== design/lbcc_pkg.sv =====
// Package: command codes, store byte indexes, reset image and shared types.
`default_nettype none
package lbcc_pkg;

  // Command opcodes
  localparam logic [7:0] CMD_GROUP        = 8'h09;
  localparam logic [7:0] CMD_SHORT_ADDR   = 8'h22;
  localparam logic [7:0] CMD_DTR_WRITE    = 8'h23;
  localparam logic [7:0] CMD_DTR_TO_STORE = 8'h24;
  localparam logic [7:0] CMD_REPLY_DTR    = 8'h25;
  localparam logic [7:0] CMD_STORE_TO_DTR = 8'h26;
  localparam logic [7:0] CMD_REPLY_LEVEL  = 8'h27;
  localparam logic [7:0] CMD_REPLY_TYPE   = 8'h31;
  localparam logic [7:0] CMD_OPEN         = 8'd40;
  localparam logic [7:0] CMD_CLOSE        = 8'd41;
  localparam logic [7:0] CMD_GOTO         = 8'd42;
  localparam logic [7:0] CMD_SCENE_STORE  = 8'd231;
  localparam logic [7:0] CMD_SCENE_RECALL = 8'd234;

  // Settings store byte indexes
  localparam logic [7:0] IDX_LEVEL  = 8'd0;
  localparam logic [7:0] IDX_MIN    = 8'd2;
  localparam logic [7:0] IDX_MAX    = 8'd3;
  localparam logic [7:0] IDX_SHORT  = 8'd6;
  localparam logic [7:0] IDX_GRP_LO = 8'd7;
  localparam logic [7:0] IDX_GRP_HI = 8'd8;
  localparam logic [7:0] IDX_SCENE  = 8'd9;
  localparam logic [7:0] IDX_ZONE   = 8'd32;

  // Other constants
  localparam logic [7:0] ADDR_BROADCAST = 8'hFF;
  localparam logic [7:0] GROUP_LOW      = 8'd191;
  localparam logic [7:0] GROUP_HIGH     = 8'd209;
  localparam logic [7:0] SHORT_LIMIT    = 8'd64;
  localparam logic [7:0] DTR_LIMIT      = 8'd33;
  localparam logic [7:0] FULL_OPEN      = 8'd100;
  localparam logic [7:0] GEAR_TYPE_CODE = 8'd3;

  // Movement kinds
  localparam logic [1:0] MOVE_CLOSE   = 2'd0;
  localparam logic [1:0] MOVE_OPEN    = 2'd1;
  localparam logic [1:0] MOVE_PARTIAL = 2'd2;

  // Request from the command logic to the settings store
  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_idx;
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
  } store_req_t;

  // Reset image of the settings store
  function automatic logic [7:0] rom_byte(input logic [7:0] idx);
    logic [7:0] v;
    unique case (idx)
      8'd0:     v = 8'd100;
      8'd1:     v = 8'd50;
      8'd3:     v = 8'd100;
      8'd4:     v = 8'd5;
      8'd5:     v = 8'd6;
      8'd6:     v = 8'd65;
      8'd7:     v = 8'd1;
      8'd9:     v = 8'd6;
      8'd10:    v = 8'd7;
      8'd11:    v = 8'd8;
      IDX_ZONE: v = 8'd255;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/lbcc_if.sv =====
// Channel interfaces: forward frame in, command result out.
`default_nettype none
interface lbcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [7:0] frame_data;

  modport source (output valid, frame_address, frame_command, frame_data, input ready);
  modport sink   (input valid, frame_address, frame_command, frame_data, output ready);
endinterface

interface lbcc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        reply_valid;
  logic [7:0]  reply_addr;
  logic [7:0]  reply_value;
  logic        move_valid;
  logic [1:0]  move_kind;
  logic [10:0] travel_ms;
  logic [7:0]  level_now;

  modport source (output valid, accepted, reply_valid, reply_addr, reply_value,
                  move_valid, move_kind, travel_ms, level_now, input ready);
  modport sink   (input valid, accepted, reply_valid, reply_addr, reply_value,
                  move_valid, move_kind, travel_ms, level_now, output ready);
endinterface
`default_nettype wire

// ===== design/lbcc_store.sv =====
// Settings store: synchronous byte memory with per-entry valid bits over the reset image.
`default_nettype none
module lbcc_store #(
  parameter int STORE_DEPTH = 33
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lbcc_pkg::store_req_t req,
  output logic [7:0]               rd_data
);

  localparam int IdxW = $clog2(STORE_DEPTH);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [7:0]             mem_q_r;
  logic [7:0]             rom_q_r;
  logic                   valid_q_r;
  logic                   rd_in_range;
  logic                   wr_in_range;

  assign rd_in_range = req.rd_idx < 8'(STORE_DEPTH);
  assign wr_in_range = req.wr_idx < 8'(STORE_DEPTH);

  // Entry written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en && wr_in_range) begin
      valid_r[req.wr_idx[IdxW-1:0]] <= 1'b1;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[req.wr_idx[IdxW-1:0]] <= req.wr_data;
    end
  end

  // Registered read, with the reset image alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_q_r <= 1'b0;
    end else if (req.rd_en) begin
      valid_q_r <= rd_in_range && valid_r[req.rd_idx[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (rd_in_range) begin
        mem_q_r <= mem[req.rd_idx[IdxW-1:0]];
      end
      rom_q_r <= lbcc_pkg::rom_byte(req.rd_idx);
    end
  end

  assign rd_data = valid_q_r ? mem_q_r : rom_q_r;

endmodule
`default_nettype wire

// ===== design/lighting_bus_curtain_command_unit.sv =====
// A frame is accepted in the idle state and executed in the exec state, which waits
// while an earlier result is still held; no new frame is taken until the exec state ends.
// A result waiting on the output does not stop the next frame from being taken in.
// Reset: synchronous, active low; store valid bits clear at once so the store reads
// as its reset image immediately, with no clearing pass. Level and DTR reset to 0.
`default_nettype none
module lighting_bus_curtain_command_unit #(
  parameter int STORE_DEPTH = 33,
  parameter int SCENE_COUNT = 17
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lbcc_in_if.sink   in_ch,
  lbcc_out_if.source out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  // Held frame
  logic [7:0] addr_r, cmd_r, data_r;

  // Control state and mirrored store bytes
  logic [7:0] level_r, level_nxt;
  logic [7:0] dtr_r, dtr_nxt;
  logic       rdy_r, rdy_nxt;
  logic [7:0] byte0_r, byte0_nxt;
  logic [7:0] min_r, min_nxt;
  logic [7:0] max_r, max_nxt;
  logic [7:0] short_r, short_nxt;
  logic [7:0] grp_lo_r, grp_lo_nxt;
  logic [7:0] grp_hi_r, grp_hi_nxt;
  logic [7:0] zone_r, zone_nxt;

  // Output register
  logic        out_valid_r;
  logic        acc_r, reply_r, move_r;
  logic [7:0]  raddr_r, rval_r, lvl_out_r;
  logic [1:0]  kind_r;
  logic [10:0] travel_r;

  logic        acc, reply, move;
  logic [7:0]  raddr, rval;
  logic [1:0]  kind;
  logic [10:0] travel;

  logic                 in_fire, exec_fire, match;
  logic [15:0]          grp_mask, grp_bit, grp_new;
  logic [7:0]           st_rdata, rd_val, rd_idx_exec, scene_lvl;
  logic                 wr_en;
  logic [7:0]           wr_idx, wr_val;
  lbcc_pkg::store_req_t st_req;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_fire   = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  // Store read is issued on accept; write-back happens in the exec cycle
  always_comb begin
    st_req.rd_en   = in_fire;
    st_req.rd_idx  = (in_ch.frame_command == lbcc_pkg::CMD_SCENE_RECALL)
                   ? lbcc_pkg::IDX_SCENE + in_ch.frame_data : in_ch.frame_data;
    st_req.wr_en   = exec_fire && wr_en;
    st_req.wr_idx  = wr_idx;
    st_req.wr_data = wr_val;
  end

  lbcc_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (st_req),
    .rd_data(st_rdata)
  );

  // Mirrored bytes are never read from memory
  assign rd_idx_exec = (cmd_r == lbcc_pkg::CMD_SCENE_RECALL)
                     ? lbcc_pkg::IDX_SCENE + data_r : data_r;
  always_comb begin
    case (rd_idx_exec)
      lbcc_pkg::IDX_LEVEL:  rd_val = byte0_r;
      lbcc_pkg::IDX_MIN:    rd_val = min_r;
      lbcc_pkg::IDX_MAX:    rd_val = max_r;
      lbcc_pkg::IDX_SHORT:  rd_val = short_r;
      lbcc_pkg::IDX_GRP_LO: rd_val = grp_lo_r;
      lbcc_pkg::IDX_GRP_HI: rd_val = grp_hi_r;
      lbcc_pkg::IDX_ZONE:   rd_val = zone_r;
      default:              rd_val = st_rdata;
    endcase
  end

  // Address match
  assign grp_mask = {grp_hi_r, grp_lo_r};
  assign match = (addr_r == lbcc_pkg::ADDR_BROADCAST) || (addr_r == short_r) ||
                 (addr_r == zone_r) ||
                 ((addr_r > lbcc_pkg::GROUP_LOW) && (addr_r < lbcc_pkg::GROUP_HIGH) &&
                  grp_mask[addr_r[3:0]]);

  assign grp_bit   = 16'd1 << data_r[3:0];
  assign grp_new   = data_r[4] ? (grp_mask | grp_bit) : (grp_mask & ~grp_bit);
  assign scene_lvl = (rd_val <= min_r) ? 8'd0 : rd_val;

  // Command execution
  always_comb begin
    level_nxt  = level_r;
    dtr_nxt    = dtr_r;
    rdy_nxt    = rdy_r;
    byte0_nxt  = byte0_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    short_nxt  = short_r;
    grp_lo_nxt = grp_lo_r;
    grp_hi_nxt = grp_hi_r;
    zone_nxt   = zone_r;
    acc        = 1'b0;
    reply      = 1'b0;
    move       = 1'b0;
    rval       = 8'd0;
    raddr      = 8'd0;
    wr_en      = 1'b0;
    wr_idx     = data_r;
    wr_val     = dtr_r;
    if (match) begin
      acc = 1'b1;
      case (cmd_r)
        lbcc_pkg::CMD_GOTO: begin
          if (data_r > max_r) level_nxt = max_r;
          else if (data_r < min_r) level_nxt = min_r;
          else level_nxt = data_r;
          move = 1'b1;
        end
        lbcc_pkg::CMD_OPEN: begin
          level_nxt = lbcc_pkg::FULL_OPEN;
          move      = 1'b1;
        end
        lbcc_pkg::CMD_CLOSE: begin
          level_nxt = 8'd0;
          move      = 1'b1;
        end
        lbcc_pkg::CMD_SCENE_RECALL: begin
          if (data_r < 8'(SCENE_COUNT)) level_nxt = scene_lvl;
          move = 1'b1;
        end
        lbcc_pkg::CMD_SCENE_STORE: begin
          if (data_r < 8'(SCENE_COUNT)) begin
            wr_en  = 1'b1;
            wr_idx = lbcc_pkg::IDX_SCENE + data_r;
            wr_val = level_r;
          end
        end
        lbcc_pkg::CMD_GROUP: begin
          grp_lo_nxt = grp_new[7:0];
          grp_hi_nxt = grp_new[15:8];
        end
        lbcc_pkg::CMD_SHORT_ADDR: begin
          if (data_r < lbcc_pkg::SHORT_LIMIT) short_nxt = data_r;
        end
        lbcc_pkg::CMD_DTR_WRITE: begin
          dtr_nxt = data_r;
          rdy_nxt = 1'b1;
        end
        lbcc_pkg::CMD_DTR_TO_STORE: begin
          if (rdy_r && (data_r < lbcc_pkg::DTR_LIMIT)) begin
            rdy_nxt = 1'b0;
            wr_en   = 1'b1;
          end
        end
        lbcc_pkg::CMD_REPLY_DTR: begin
          reply = 1'b1;
          rval  = dtr_r;
        end
        lbcc_pkg::CMD_STORE_TO_DTR: begin
          if (data_r < lbcc_pkg::DTR_LIMIT) dtr_nxt = rd_val;
        end
        lbcc_pkg::CMD_REPLY_LEVEL: begin
          reply = 1'b1;
          rval  = byte0_r;
        end
        lbcc_pkg::CMD_REPLY_TYPE: begin
          reply = 1'b1;
          rval  = lbcc_pkg::GEAR_TYPE_CODE;
        end
        default: acc = 1'b0;
      endcase
      if (reply) raddr = short_r;
      // Keep mirrored bytes in step with store writes
      if (wr_en) begin
        case (wr_idx)
          lbcc_pkg::IDX_LEVEL:  byte0_nxt  = wr_val;
          lbcc_pkg::IDX_MIN:    min_nxt    = wr_val;
          lbcc_pkg::IDX_MAX:    max_nxt    = wr_val;
          lbcc_pkg::IDX_SHORT:  short_nxt  = wr_val;
          lbcc_pkg::IDX_GRP_LO: grp_lo_nxt = wr_val;
          lbcc_pkg::IDX_GRP_HI: grp_hi_nxt = wr_val;
          lbcc_pkg::IDX_ZONE:   zone_nxt   = wr_val;
          default: ;
        endcase
      end
      if (acc) byte0_nxt = level_nxt;
    end
  end

  // Movement mapping
  always_comb begin
    kind   = lbcc_pkg::MOVE_CLOSE;
    travel = 11'd0;
    if (move) begin
      if (level_nxt == 8'd0) begin
        kind = lbcc_pkg::MOVE_CLOSE;
      end else if (level_nxt == lbcc_pkg::FULL_OPEN) begin
        kind = lbcc_pkg::MOVE_OPEN;
      end else if (level_nxt < lbcc_pkg::FULL_OPEN) begin
        kind   = lbcc_pkg::MOVE_PARTIAL;
        travel = (11'(level_nxt) << 4) + (11'(level_nxt) << 2);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Frame capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r <= in_ch.frame_address;
      cmd_r  <= in_ch.frame_command;
      data_r <= in_ch.frame_data;
    end
  end

  // Control state and mirrors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      level_r  <= 8'd0;
      dtr_r    <= 8'd0;
      rdy_r    <= 1'b0;
      byte0_r  <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_LEVEL);
      min_r    <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_MIN);
      max_r    <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_MAX);
      short_r  <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_SHORT);
      grp_lo_r <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_GRP_LO);
      grp_hi_r <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_GRP_HI);
      zone_r   <= lbcc_pkg::rom_byte(lbcc_pkg::IDX_ZONE);
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        level_r  <= level_nxt;
        dtr_r    <= dtr_nxt;
        rdy_r    <= rdy_nxt;
        byte0_r  <= byte0_nxt;
        min_r    <= min_nxt;
        max_r    <= max_nxt;
        short_r  <= short_nxt;
        grp_lo_r <= grp_lo_nxt;
        grp_hi_r <= grp_hi_nxt;
        zone_r   <= zone_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      acc_r     <= acc;
      reply_r   <= reply;
      raddr_r   <= raddr;
      rval_r    <= rval;
      move_r    <= move;
      kind_r    <= kind;
      travel_r  <= travel;
      lvl_out_r <= level_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = acc_r;
  assign out_ch.reply_valid = reply_r;
  assign out_ch.reply_addr  = raddr_r;
  assign out_ch.reply_value = rval_r;
  assign out_ch.move_valid  = move_r;
  assign out_ch.move_kind   = kind_r;
  assign out_ch.travel_ms   = travel_r;
  assign out_ch.level_now   = lvl_out_r;

endmodule
`default_nettype wire

// ===== bench/tb_lighting_bus_curtain_command_unit.sv =====
// Testbench for the curtain command unit: random and directed frames, scoreboard against a shadow model.
`timescale 1ns / 100ps
module tb_lighting_bus_curtain_command_unit;

  localparam int STORE_BYTES = 33;
  localparam int SCENES = 17;
  localparam int RANDOM_FRAMES = 1900;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED = 40;
  localparam logic [10:0] MS_PER_LEVEL_STEP = 11'd20;
  localparam logic [7:0] POWER_ON_IMAGE [0:11] =
    '{8'd100, 8'd50, 8'd0, 8'd100, 8'd5, 8'd6, 8'd65, 8'd1, 8'd0, 8'd6, 8'd7, 8'd8};
  localparam logic [7:0] KNOWN_CMDS [0:12] = '{
    lbcc_pkg::CMD_GROUP, lbcc_pkg::CMD_SHORT_ADDR, lbcc_pkg::CMD_DTR_WRITE,
    lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::CMD_REPLY_DTR, lbcc_pkg::CMD_STORE_TO_DTR,
    lbcc_pkg::CMD_REPLY_LEVEL, lbcc_pkg::CMD_REPLY_TYPE, lbcc_pkg::CMD_OPEN,
    lbcc_pkg::CMD_CLOSE, lbcc_pkg::CMD_GOTO, lbcc_pkg::CMD_SCENE_STORE,
    lbcc_pkg::CMD_SCENE_RECALL};

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] data;
  } frame_t;

  typedef struct packed {
    logic        accepted;
    logic        reply_valid;
    logic [7:0]  reply_addr;
    logic [7:0]  reply_value;
    logic        move_valid;
    logic [1:0]  move_kind;
    logic [10:0] travel_ms;
    logic [7:0]  level_now;
  } outcome_t;

  logic clk;
  logic rst_n;

  lbcc_in_if  frame_ch ();
  lbcc_out_if result_ch ();

  lighting_bus_curtain_command_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (frame_ch),
    .out_ch (result_ch)
  );

  // Shadow copy of the unit's state
  logic [7:0] shadow_store [0:STORE_BYTES-1];
  logic [7:0] shadow_level;
  logic [7:0] shadow_dtr;
  logic       shadow_dtr_ready;

  frame_t   pending_frames[$];
  outcome_t expected_outcomes[$];
  frame_t   frame_on_bus;

  int unsigned cycle_no = 0;
  int unsigned mismatch_count = 0;
  int unsigned frames_taken = 0;
  int unsigned results_checked = 0;
  int unsigned accepted_seen = 0;
  int unsigned replies_seen = 0;
  int unsigned moves_seen = 0;

  // Stimulus-side guesses of which addresses currently match
  logic [7:0] gen_short = 8'd65;
  logic [3:0] gen_group = 4'd0;
  logic [7:0] gen_zone = lbcc_pkg::ADDR_BROADCAST;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Random stall; a quiet window in the middle of the run has none
  function automatic logic take_break();
    if (cycle_no >= 1500 && cycle_no < 3000) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  function automatic logic frame_matches(input logic [7:0] a);
    logic [15:0] mask;
    mask = {shadow_store[lbcc_pkg::IDX_GRP_HI], shadow_store[lbcc_pkg::IDX_GRP_LO]};
    if (a == lbcc_pkg::ADDR_BROADCAST || a == shadow_store[lbcc_pkg::IDX_SHORT] ||
        a == shadow_store[lbcc_pkg::IDX_ZONE])
      return 1'b1;
    if (a > lbcc_pkg::GROUP_LOW && a < lbcc_pkg::GROUP_HIGH) return mask[a[3:0]];
    return 1'b0;
  endfunction

  // Executes one frame on the shadow state and returns the result it must produce
  function automatic outcome_t apply_frame(input frame_t f);
    outcome_t    o;
    logic [7:0]  lo_lim;
    logic [7:0]  hi_lim;
    logic [7:0]  lvl;
    logic [15:0] mask;
    o = '0;
    lvl = shadow_level;
    if (frame_matches(f.addr)) begin
      lo_lim = shadow_store[lbcc_pkg::IDX_MIN];
      hi_lim = shadow_store[lbcc_pkg::IDX_MAX];
      o.accepted = 1'b1;
      case (f.cmd)
        lbcc_pkg::CMD_GOTO: begin
          // max test first, so min above max still yields max when data is high
          if (f.data > hi_lim) lvl = hi_lim;
          else if (f.data < lo_lim) lvl = lo_lim;
          else lvl = f.data;
          o.move_valid = 1'b1;
        end
        lbcc_pkg::CMD_OPEN: begin
          lvl = lbcc_pkg::FULL_OPEN;
          o.move_valid = 1'b1;
        end
        lbcc_pkg::CMD_CLOSE: begin
          lvl = '0;
          o.move_valid = 1'b1;
        end
        lbcc_pkg::CMD_SCENE_RECALL: begin
          if (f.data < SCENES) begin
            lvl = shadow_store[lbcc_pkg::IDX_SCENE + f.data];
            if (lvl <= lo_lim) lvl = '0;
          end
          o.move_valid = 1'b1;
        end
        lbcc_pkg::CMD_SCENE_STORE: begin
          if (f.data < SCENES) shadow_store[lbcc_pkg::IDX_SCENE + f.data] = lvl;
        end
        lbcc_pkg::CMD_GROUP: begin
          mask = {shadow_store[lbcc_pkg::IDX_GRP_HI], shadow_store[lbcc_pkg::IDX_GRP_LO]};
          mask[f.data[3:0]] = f.data[4];
          shadow_store[lbcc_pkg::IDX_GRP_LO] = mask[7:0];
          shadow_store[lbcc_pkg::IDX_GRP_HI] = mask[15:8];
        end
        lbcc_pkg::CMD_SHORT_ADDR: begin
          if (f.data < lbcc_pkg::SHORT_LIMIT) shadow_store[lbcc_pkg::IDX_SHORT] = f.data;
        end
        lbcc_pkg::CMD_DTR_WRITE: begin
          shadow_dtr = f.data;
          shadow_dtr_ready = 1'b1;
        end
        lbcc_pkg::CMD_DTR_TO_STORE: begin
          if (shadow_dtr_ready && f.data < lbcc_pkg::DTR_LIMIT) begin
            shadow_dtr_ready = 1'b0;
            shadow_store[f.data] = shadow_dtr;
          end
        end
        lbcc_pkg::CMD_REPLY_DTR: begin
          o.reply_valid = 1'b1;
          o.reply_value = shadow_dtr;
        end
        lbcc_pkg::CMD_STORE_TO_DTR: begin
          if (f.data < lbcc_pkg::DTR_LIMIT) shadow_dtr = shadow_store[f.data];
        end
        lbcc_pkg::CMD_REPLY_LEVEL: begin
          o.reply_valid = 1'b1;
          o.reply_value = shadow_store[lbcc_pkg::IDX_LEVEL];
        end
        lbcc_pkg::CMD_REPLY_TYPE: begin
          o.reply_valid = 1'b1;
          o.reply_value = lbcc_pkg::GEAR_TYPE_CODE;
        end
        default: o.accepted = 1'b0;
      endcase
      if (o.reply_valid) o.reply_addr = shadow_store[lbcc_pkg::IDX_SHORT];
      if (o.accepted) shadow_store[lbcc_pkg::IDX_LEVEL] = lvl;
    end
    shadow_level = lvl;
    // Movement mapping; a level above full open closes
    if (o.move_valid) begin
      if (lvl == '0) begin
        o.move_kind = lbcc_pkg::MOVE_CLOSE;
      end else if (lvl == lbcc_pkg::FULL_OPEN) begin
        o.move_kind = lbcc_pkg::MOVE_OPEN;
      end else if (lvl < lbcc_pkg::FULL_OPEN) begin
        o.move_kind = lbcc_pkg::MOVE_PARTIAL;
        o.travel_ms = 11'(lvl) * MS_PER_LEVEL_STEP;
      end else begin
        o.move_kind = lbcc_pkg::MOVE_CLOSE;
      end
    end
    o.level_now = lvl;
    return o;
  endfunction

  task automatic add_frame(input logic [7:0] a, input logic [7:0] c, input logic [7:0] d);
    frame_t f;
    f.addr = a;
    f.cmd = c;
    f.data = d;
    pending_frames.push_back(f);
  endtask

  function automatic logic [7:0] random_known_cmd();
    return KNOWN_CMDS[$urandom_range(0, 12)];
  endfunction

  function automatic logic [7:0] group_addr(input logic [3:0] g);
    if (g == 4'd0 && $urandom_range(0, 1) == 1) return lbcc_pkg::GROUP_HIGH - 8'd1;
    return lbcc_pkg::GROUP_LOW + 8'd1 + 8'(g);
  endfunction

  // Address likely to match right now
  function automatic logic [7:0] pick_target();
    case ($urandom_range(0, 3))
      0: return lbcc_pkg::ADDR_BROADCAST;
      1: return gen_short;
      2: return group_addr(gen_group);
      default: return gen_zone;
    endcase
  endfunction

  task automatic add_movement(input logic [7:0] a);
    case ($urandom_range(0, 4))
      0: add_frame(a, lbcc_pkg::CMD_GOTO, ($urandom_range(0, 1) == 1)
                                          ? 8'($urandom) : 8'($urandom_range(0, 110)));
      1: add_frame(a, lbcc_pkg::CMD_OPEN, 8'($urandom));
      2: add_frame(a, lbcc_pkg::CMD_CLOSE, 8'($urandom));
      3: add_frame(a, lbcc_pkg::CMD_SCENE_RECALL, 8'($urandom_range(0, 19)));
      default: add_frame(a, lbcc_pkg::CMD_SCENE_STORE, 8'($urandom_range(0, 19)));
    endcase
  endtask

  // Frame driver
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_ch.valid <= 1'b0;
      frame_ch.frame_address <= '0;
      frame_ch.frame_command <= '0;
      frame_ch.frame_data <= '0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        expected_outcomes.push_back(apply_frame(frame_on_bus));
        frames_taken++;
      end
      if (!frame_ch.valid || frame_ch.ready) begin
        if (pending_frames.size() != 0 && !take_break()) begin
          frame_on_bus = pending_frames.pop_front();
          frame_ch.valid <= 1'b1;
          frame_ch.frame_address <= frame_on_bus.addr;
          frame_ch.frame_command <= frame_on_bus.cmd;
          frame_ch.frame_data <= frame_on_bus.data;
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk) begin : result_check
    outcome_t seen;
    outcome_t want;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen = '{result_ch.accepted, result_ch.reply_valid, result_ch.reply_addr,
                 result_ch.reply_value, result_ch.move_valid, result_ch.move_kind,
                 result_ch.travel_ms, result_ch.level_now};
        if (expected_outcomes.size() == 0) begin
          report("result with no frame waiting for it");
        end else begin
          want = expected_outcomes.pop_front();
          results_checked++;
          accepted_seen += want.accepted;
          replies_seen += want.reply_valid;
          moves_seen += want.move_valid;
          check_field("accepted", seen.accepted, want.accepted);
          check_field("reply_valid", seen.reply_valid, want.reply_valid);
          check_field("reply_addr", seen.reply_addr, want.reply_addr);
          check_field("reply_value", seen.reply_value, want.reply_value);
          check_field("move_valid", seen.move_valid, want.move_valid);
          check_field("move_kind", seen.move_kind, want.move_kind);
          check_field("travel_ms", seen.travel_ms, want.travel_ms);
          check_field("level_now", seen.level_now, want.level_now);
        end
      end
      result_ch.ready <= !take_break();
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int         roll;
    int         n;
    int         target_total;
    logic [7:0] a;
    logic [7:0] v;
    logic [7:0] idx;

    rst_n = 1'b0;

    for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = (i < 12) ? POWER_ON_IMAGE[i] : 8'd0;
    shadow_store[lbcc_pkg::IDX_ZONE] = 8'hFF;
    shadow_level = '0;
    shadow_dtr = '0;
    shadow_dtr_ready = 1'b0;

    // Directed opening: reset image, clamping, movement mapping, scenes, groups, DTR
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_REPLY_TYPE, 8'd0);
    add_frame(8'd65, lbcc_pkg::CMD_GOTO, 8'd255);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GOTO, 8'd55);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SCENE_RECALL, 8'd0);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SCENE_RECALL, 8'd16);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SCENE_RECALL, 8'd17);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_OPEN, 8'd0);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SCENE_STORE, 8'd16);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_CLOSE, 8'd0);
    // group 208 picks mask bit 0
    add_frame(lbcc_pkg::GROUP_HIGH - 8'd1, lbcc_pkg::CMD_GOTO, 8'd99);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GROUP, 8'h15);
    add_frame(8'd197, lbcc_pkg::CMD_REPLY_LEVEL, 8'd0);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GROUP, 8'h05);
    add_frame(8'd197, lbcc_pkg::CMD_OPEN, 8'd0);                   // bit just cleared
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SHORT_ADDR, lbcc_pkg::SHORT_LIMIT);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SHORT_ADDR,
              lbcc_pkg::SHORT_LIMIT - 8'd1);
    add_frame(lbcc_pkg::SHORT_LIMIT - 8'd1, lbcc_pkg::CMD_DTR_WRITE, 8'd150);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::DTR_LIMIT);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::IDX_MAX);
    // DTR no longer ready
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::IDX_MAX);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GOTO, 8'd120);  // above full open closes
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_STORE_TO_DTR, 8'd40);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_STORE_TO_DTR, lbcc_pkg::IDX_MIN);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_REPLY_DTR, 8'd0);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_WRITE, 8'd200);
    // min now above max
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::IDX_MIN);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GOTO, 8'd170);
    add_frame(lbcc_pkg::ADDR_BROADCAST, 8'h00, 8'd0);                 // unknown command
    add_frame(8'd80, lbcc_pkg::CMD_REPLY_TYPE, 8'd0);                 // unmatched address
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_WRITE, 8'd0);
    add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_DTR_TO_STORE, lbcc_pkg::IDX_MIN);
    gen_short = lbcc_pkg::SHORT_LIMIT - 8'd1;

    // Random part: mostly well-formed sequences, some noise and broken ones
    target_total = pending_frames.size() + RANDOM_FRAMES;
    while (pending_frames.size() < target_total) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        add_frame(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 20) begin
        if ($urandom_range(0, 1) == 1)
          add_frame(8'($urandom_range(66, 190)), random_known_cmd(), 8'($urandom));
        else
          add_frame(pick_target(), lbcc_pkg::CMD_DTR_TO_STORE, 8'($urandom_range(0, 40)));
      end else if (roll < 45) begin
        n = $urandom_range(1, 4);
        a = pick_target();
        repeat (n) add_movement(a);
      end else if (roll < 65) begin
        // DTR write then store, aimed mostly at bytes that steer behavior
        a = pick_target();
        v = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 110)) : 8'($urandom);
        case ($urandom_range(0, 9))
          0: begin
            idx = lbcc_pkg::IDX_MIN;
            v = 8'($urandom_range(0, 30));
          end
          1: begin
            idx = lbcc_pkg::IDX_MAX;
            v = 8'($urandom_range(60, 255));
          end
          2, 3, 4: idx = lbcc_pkg::IDX_SCENE + 8'($urandom_range(0, SCENES - 1));
          5: begin
            idx = lbcc_pkg::IDX_SHORT;
            v = 8'($urandom_range(0, 70));
            gen_short = v;
          end
          6: begin
            idx = lbcc_pkg::IDX_ZONE;
            gen_zone = v;
          end
          7: idx = ($urandom_range(0, 1) == 1) ? lbcc_pkg::IDX_GRP_LO : lbcc_pkg::IDX_GRP_HI;
          8: idx = 8'($urandom_range(0, 40));
          default: idx = lbcc_pkg::IDX_LEVEL;
        endcase
        add_frame(a, lbcc_pkg::CMD_DTR_WRITE, v);
        add_frame(a, lbcc_pkg::CMD_DTR_TO_STORE, idx);
        if ($urandom_range(0, 1) == 1) begin
          add_frame(a, lbcc_pkg::CMD_STORE_TO_DTR, 8'($urandom_range(0, 36)));
          add_frame(a, lbcc_pkg::CMD_REPLY_DTR, 8'($urandom));
        end
      end else if (roll < 80) begin
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) begin
          v = 8'($urandom_range(0, 70));
          add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_SHORT_ADDR, v);
          if (v < lbcc_pkg::SHORT_LIMIT) gen_short = v;
          repeat (n) add_frame(gen_short, random_known_cmd(), 8'($urandom_range(0, 120)));
        end else begin
          v = {3'($urandom), 5'($urandom)};
          add_frame(lbcc_pkg::ADDR_BROADCAST, lbcc_pkg::CMD_GROUP, v);
          if (v[4]) gen_group = v[3:0];
          repeat (n) add_frame(group_addr(v[3:0]), random_known_cmd(),
                               8'($urandom_range(0, 120)));
        end
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: add_frame(pick_target(), lbcc_pkg::CMD_REPLY_TYPE, 8'($urandom));
            1: add_frame(pick_target(), lbcc_pkg::CMD_REPLY_LEVEL, 8'($urandom));
            default: add_frame(pick_target(), lbcc_pkg::CMD_REPLY_DTR, 8'($urandom));
          endcase
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_frames.size() != 0 || frame_ch.valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0)
      report($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Run covered %0d frames and %0d results: %0d accepted, %0d replies, %0d moves",
             frames_taken, results_checked, accepted_seen, replies_seen, moves_seen);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d frames pending and %0d results outstanding",
             pending_frames.size(), expected_outcomes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
